@@ rtl/cpos_pkg.sv @@
`default_nettype none
package cpos_pkg;

  localparam logic [1:0] REGION_BEFORE = 2'd0;
  localparam logic [1:0] REGION_INSIDE = 2'd1;
  localparam logic [1:0] REGION_AFTER  = 2'd2;

  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_START_X = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_Y = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_Z = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_END_X   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_END_Y   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_END_Z   = 3'd5;

endpackage
`default_nettype wire

@@ rtl/cpos_div_cell.sv @@
`default_nettype none
// one step of rem*2 + bit*add, quotient digit 0..2
module cpos_div_cell #(
  parameter int VW = 52,
  parameter int QW = 25
) (
  input  wire logic          clk,
  input  wire logic [VW-1:0] rem_in,
  input  wire logic [QW-1:0] quo_in,
  input  wire logic [VW-1:0] add,
  input  wire logic [VW-1:0] den,
  input  wire logic          mbit,
  output logic      [VW-1:0] rem_out,
  output logic      [QW-1:0] quo_out
);

  logic [VW-1:0] t;
  logic [VW-1:0] den2;
  logic [VW-1:0] rem_next;
  logic [1:0]    digit;

  always_comb begin
    t    = {rem_in[VW-2:0], 1'b0} + (mbit ? add : '0);
    den2 = {den[VW-2:0], 1'b0};
    if (t >= den2) begin
      rem_next = t - den2;
      digit    = 2'd2;
    end else if (t >= den) begin
      rem_next = t - den;
      digit    = 2'd1;
    end else begin
      rem_next = t;
      digit    = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    rem_out <= rem_next;
    quo_out <= {quo_in[QW-2:0], 1'b0} + QW'(digit);
  end

endmodule
`default_nettype wire

@@ rtl/cpos_sqrt_cell.sv @@
`default_nettype none
// one root bit per cell, restoring
module cpos_sqrt_cell #(
  parameter int RW = 29,
  parameter int YW = 25
) (
  input  wire logic          clk,
  input  wire logic [RW-1:0] rem_in,
  input  wire logic [YW-1:0] root_in,
  input  wire logic [1:0]    pair,
  output logic      [RW-1:0] rem_out,
  output logic      [YW-1:0] root_out
);

  logic [RW-1:0] r;
  logic [RW-1:0] trial;
  logic          ge;

  always_comb begin
    r     = {rem_in[RW-3:0], pair};
    trial = {{(RW-YW-2){1'b0}}, root_in, 2'b01};
    ge    = r >= trial;
  end

  always_ff @(posedge clk) begin
    rem_out  <= ge ? r - trial : r;
    root_out <= {root_in[YW-2:0], ge};
  end

endmodule
`default_nettype wire

@@ rtl/closest_point_on_segment_3d_unit.sv @@
`default_nettype none
// Closest point on segment S..E to query Q, with distance.
// Throughput: one request per cycle; busy stays low, the receiver cannot stall.
// The pipeline holds a chain of COORD_BITS divider cells per axis and a chain of COORD_BITS+1 root cells.
// Reset: synchronous rst clears the segment registers to zero and all valid flags.
module closest_point_on_segment_3d_unit
  import cpos_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [COORD_BITS-1:0]     query_x,
  input  wire logic [COORD_BITS-1:0]     query_y,
  input  wire logic [COORD_BITS-1:0]     query_z,
  output logic                           done,
  output logic [COORD_BITS-1:0]          near_x,
  output logic [COORD_BITS-1:0]          near_y,
  output logic [COORD_BITS-1:0]          near_z,
  output logic [COORD_BITS:0]            gap,
  output logic [1:0]                     region,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [COORD_BITS-1:0]     cfg_data
);

  localparam int CB = COORD_BITS;
  localparam int W2 = 2*CB + 4;
  localparam int NW = 2*CB + 2;
  localparam int YW = CB + 1;
  localparam int RW = CB + 5;

  logic [CB-1:0] cs [3];
  logic [CB-1:0] ce [3];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 3; c++) begin
        cs[c] <= '0;
        ce[c] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_X: cs[0] <= cfg_data;
        REG_START_Y: cs[1] <= cfg_data;
        REG_START_Z: cs[2] <= cfg_data;
        REG_END_X:   ce[0] <= cfg_data;
        REG_END_Y:   ce[1] <= cfg_data;
        REG_END_Z:   ce[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [CB:0] dvec [3];
  logic [CB-1:0]      dmag [3];
  logic signed [CB:0] dneg [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dvec[c] = $signed({ce[c][CB-1], ce[c]}) - $signed({cs[c][CB-1], cs[c]});
      dneg[c] = -dvec[c];
      dmag[c] = dvec[c][CB] ? dneg[c][CB-1:0] : dvec[c][CB-1:0];
    end
  end

  // stage A: take request
  logic          a_vld;
  logic [CB-1:0] a_q [3];

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else     a_vld <= start && !busy;
  end

  always_ff @(posedge clk) begin
    a_q[0] <= query_x;
    a_q[1] <= query_y;
    a_q[2] <= query_z;
  end

  // stage B: products
  logic                 b_vld;
  logic [CB-1:0]        b_q [3];
  logic signed [NW-1:0] b_pa [3];
  logic signed [NW-1:0] b_pl [3];
  logic signed [CB:0]   qs [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qs[c] = $signed({a_q[c][CB-1], a_q[c]}) - $signed({cs[c][CB-1], cs[c]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else     b_vld <= a_vld;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      b_q[c]  <= a_q[c];
      b_pa[c] <= qs[c] * dvec[c];
      b_pl[c] <= dvec[c] * dvec[c];
    end
  end

  // stage C: dot products
  logic                 c_vld;
  logic [CB-1:0]        c_q [3];
  logic signed [W2-1:0] c_dot;
  logic signed [W2-1:0] c_len;

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else     c_vld <= b_vld;
  end

  always_ff @(posedge clk) begin
    c_q   <= b_q;
    c_dot <= W2'(b_pa[0]) + W2'(b_pa[1]) + W2'(b_pa[2]);
    c_len <= W2'(b_pl[0]) + W2'(b_pl[1]) + W2'(b_pl[2]);
  end

  // stage D (chain slot 0): classify, load divider
  logic          v_vld    [CB+1];
  logic [CB-1:0] v_q      [CB+1][3];
  logic [1:0]    v_region [CB+1];
  logic [W2-1:0] v_dot    [CB+1];
  logic [W2-1:0] v_len    [CB+1];
  logic [W2-1:0] v_rem    [1:CB][3];
  logic [CB:0]   v_quo    [1:CB][3];
  logic [1:0]    region_next;

  always_comb begin
    if (c_dot[W2-1])       region_next = REGION_BEFORE;
    else if (c_dot > c_len) region_next = REGION_AFTER;
    else                   region_next = REGION_INSIDE;
  end

  always_ff @(posedge clk) begin
    if (rst) v_vld[0] <= 1'b0;
    else     v_vld[0] <= c_vld;
  end

  always_ff @(posedge clk) begin
    v_q[0]      <= c_q;
    v_region[0] <= region_next;
    v_dot[0]    <= (region_next == REGION_INSIDE) ? c_dot : '0;
    v_len[0]    <= c_len;
  end

  for (genvar k = 0; k < CB; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) v_vld[k+1] <= 1'b0;
      else     v_vld[k+1] <= v_vld[k];
    end

    always_ff @(posedge clk) begin
      v_q[k+1]      <= v_q[k];
      v_region[k+1] <= v_region[k];
      v_dot[k+1]    <= v_dot[k];
      v_len[k+1]    <= v_len[k];
    end

    for (genvar c = 0; c < 3; c++) begin : g_axis
      logic [W2-1:0] rin;
      logic [CB:0]   qin;
      if (k == 0) begin : g_first
        assign rin = '0;
        assign qin = '0;
      end else begin : g_rest
        assign rin = v_rem[k][c];
        assign qin = v_quo[k][c];
      end

      cpos_div_cell #(
        .VW(W2),
        .QW(CB+1)
      ) u_cell (
        .clk     (clk),
        .rem_in  (rin),
        .quo_in  (qin),
        .add     (v_dot[k]),
        .den     (v_len[k]),
        .mbit    (dmag[c][CB-1-k]),
        .rem_out (v_rem[k+1][c]),
        .quo_out (v_quo[k+1][c])
      );
    end
  end

  // stage E: nearest point
  logic          e_vld;
  logic [CB-1:0] e_q [3];
  logic [CB-1:0] e_p [3];
  logic [1:0]    e_region;
  logic [CB:0]   off [3];
  logic [CB+1:0] pin [3];
  logic [CB+1:0] ps  [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      off[c] = v_quo[CB][c] +
               (CB+1)'({v_rem[CB][c], 1'b0} >= {1'b0, v_len[CB]});
      ps[c]  = {cs[c][CB-1], cs[c][CB-1], cs[c]};
      pin[c] = dvec[c][CB] ? ps[c] - {1'b0, off[c]} : ps[c] + {1'b0, off[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) e_vld <= 1'b0;
    else     e_vld <= v_vld[CB];
  end

  always_ff @(posedge clk) begin
    e_q      <= v_q[CB];
    e_region <= v_region[CB];
    for (int c = 0; c < 3; c++) begin
      case (v_region[CB])
        REGION_BEFORE: e_p[c] <= cs[c];
        REGION_AFTER:  e_p[c] <= ce[c];
        default:       e_p[c] <= (v_len[CB] == '0) ? cs[c] : pin[c][CB-1:0];
      endcase
    end
  end

  // stage F: squared differences
  logic              f_vld;
  logic [CB-1:0]     f_p [3];
  logic [1:0]        f_region;
  logic [2*CB-1:0]   f_sq [3];
  logic signed [CB:0] gdiff [3];
  logic signed [CB:0] gneg  [3];
  logic [CB-1:0]     gmag  [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      gdiff[c] = $signed({e_q[c][CB-1], e_q[c]}) - $signed({e_p[c][CB-1], e_p[c]});
      gneg[c]  = -gdiff[c];
      gmag[c]  = gdiff[c][CB] ? gneg[c][CB-1:0] : gdiff[c][CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) f_vld <= 1'b0;
    else     f_vld <= e_vld;
  end

  always_ff @(posedge clk) begin
    f_p      <= e_p;
    f_region <= e_region;
    for (int c = 0; c < 3; c++) begin
      f_sq[c] <= gmag[c] * gmag[c];
    end
  end

  // stage G (root slot 0): sum of squares
  logic          w_vld    [CB+2];
  logic [CB-1:0] w_p      [CB+2][3];
  logic [1:0]    w_region [CB+2];
  logic [NW-1:0] w_n      [CB+2];
  logic [RW-1:0] w_rem    [1:CB+1];
  logic [YW-1:0] w_root   [1:CB+1];

  always_ff @(posedge clk) begin
    if (rst) w_vld[0] <= 1'b0;
    else     w_vld[0] <= f_vld;
  end

  always_ff @(posedge clk) begin
    w_p[0]      <= f_p;
    w_region[0] <= f_region;
    w_n[0]      <= NW'(f_sq[0]) + NW'(f_sq[1]) + NW'(f_sq[2]);
  end

  for (genvar k = 0; k <= CB; k++) begin : g_root
    logic [RW-1:0] rin;
    logic [YW-1:0] yin;

    always_ff @(posedge clk) begin
      if (rst) w_vld[k+1] <= 1'b0;
      else     w_vld[k+1] <= w_vld[k];
    end

    always_ff @(posedge clk) begin
      w_p[k+1]      <= w_p[k];
      w_region[k+1] <= w_region[k];
      w_n[k+1]      <= w_n[k];
    end

    if (k == 0) begin : g_first
      assign rin = '0;
      assign yin = '0;
    end else begin : g_rest
      assign rin = w_rem[k];
      assign yin = w_root[k];
    end

    cpos_sqrt_cell #(
      .RW(RW),
      .YW(YW)
    ) u_cell (
      .clk      (clk),
      .rem_in   (rin),
      .root_in  (yin),
      .pair     (w_n[k][NW-1-2*k -: 2]),
      .rem_out  (w_rem[k+1]),
      .root_out (w_root[k+1])
    );
  end

  // output register
  logic [YW:0] gap_sum;

  assign gap_sum = {1'b0, w_root[CB+1]} +
                   (YW+1)'(w_rem[CB+1] > {{(RW-YW){1'b0}}, w_root[CB+1]});

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= w_vld[CB+1];
  end

  always_ff @(posedge clk) begin
    near_x <= w_p[CB+1][0];
    near_y <= w_p[CB+1][1];
    near_z <= w_p[CB+1][2];
    region <= w_region[CB+1];
    gap    <= gap_sum[YW] ? '1 : gap_sum[YW-1:0];
  end

`ifndef SYNTHESIS
  a_before_is_start: assert property (@(posedge clk) disable iff (rst)
    done && region == REGION_BEFORE |-> near_x == cs[0] && near_y == cs[1] && near_z == cs[2])
    else $error("before-start request did not return the start point");

  a_after_is_end: assert property (@(posedge clk) disable iff (rst)
    done && region == REGION_AFTER |-> near_x == ce[0] && near_y == ce[1] && near_z == ce[2])
    else $error("past-end request did not return the end point");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    a_vld |-> ##(2*COORD_BITS+8) done)
    else $error("request lost in pipeline");

  a_no_region3: assert property (@(posedge clk) disable iff (rst)
    done |-> region == REGION_BEFORE || region == REGION_INSIDE || region == REGION_AFTER)
    else $error("bad region code");
`endif

endmodule
`default_nettype wire
